>>> rtl/i3u8_pkg.sv
package i3u8_pkg;

    // Text encoding selected by the encoding byte of a frame
    typedef enum logic [1:0] {
        MODE_RAW = 2'd0,
        MODE_ISO = 2'd1,
        MODE_U16 = 2'd2
    } text_mode_t;

    // Encoding byte codes
    localparam logic [7:0] ENC_ISO = 8'h00;
    localparam logic [7:0] ENC_U16 = 8'h01;

    // Byte order marks
    localparam logic [7:0] BOM_FE = 8'hFE;
    localparam logic [7:0] BOM_FF = 8'hFF;

    // UTF-8 lead and continuation prefixes, limits and masks
    localparam logic [7:0]  LEAD2     = 8'hC0;
    localparam logic [7:0]  LEAD3     = 8'hE0;
    localparam logic [7:0]  CONT      = 8'h80;
    localparam logic [15:0] ONE_MAX   = 16'h007F;
    localparam logic [15:0] TWO_MAX   = 16'h07FF;
    localparam logic [7:0]  TERM_BYTE = 8'h00;

    // Payload position saturates here
    localparam logic [1:0] POS_SAT = 2'd2;

    // Output bytes caused by one request, handed from front to back
    typedef struct packed {
        logic [3:0][7:0] bytes;  // bytes[0] goes out first
        logic [2:0]      cnt;    // 1 to 4
        logic            eot;    // end of text on the final byte
    } job_t;

endpackage

>>> rtl/i3u8_front.sv
module i3u8_front
    import i3u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       acc,
    input  logic [7:0] data_byte,
    input  logic       first_of_frame,
    input  logic       last_of_frame,
    output logic       push,
    output job_t       job
);

    text_mode_t mode_reg, mode_next;
    logic [1:0] pos_reg, pos_next;
    logic [7:0] held_reg, held_next;
    logic       have_reg, have_next;
    logic       be_reg, be_next;

    logic [15:0] code;
    logic [1:0]  n;
    logic        bom;

    // Frame state update and classification of one request
    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        held_next = held_reg;
        have_next = have_reg;
        be_next   = be_reg;
        job       = '0;
        n         = 2'd0;
        code      = be_reg ? {held_reg, data_byte} : {data_byte, held_reg};
        bom       = (pos_reg == 2'd1) &&
                    (((held_reg == BOM_FE) && (data_byte == BOM_FF)) ||
                     ((held_reg == BOM_FF) && (data_byte == BOM_FE)));

        if (first_of_frame) begin
            pos_next  = 2'd0;
            held_next = '0;
            have_next = 1'b0;
            be_next   = 1'b0;
            if (data_byte == ENC_ISO) begin
                mode_next = MODE_ISO;
            end else if (data_byte == ENC_U16) begin
                mode_next = MODE_U16;
            end else begin
                mode_next = MODE_RAW;
            end
        end else if (mode_reg == MODE_ISO) begin
            if (!data_byte[7]) begin
                job.bytes[0] = data_byte;
                n = 2'd1;
            end else begin
                job.bytes[0] = LEAD2 | {6'd0, data_byte[7:6]};
                job.bytes[1] = CONT | {2'd0, data_byte[5:0]};
                n = 2'd2;
            end
        end else if (mode_reg == MODE_U16) begin
            if (!have_reg) begin
                held_next = data_byte;
                have_next = 1'b1;
            end else begin
                have_next = 1'b0;
                if (bom) begin
                    be_next = (held_reg == BOM_FE);
                end else if (code <= ONE_MAX) begin
                    job.bytes[0] = code[7:0];
                    n = 2'd1;
                end else if (code <= TWO_MAX) begin
                    job.bytes[0] = LEAD2 | {3'd0, code[10:6]};
                    job.bytes[1] = CONT | {2'd0, code[5:0]};
                    n = 2'd2;
                end else begin
                    job.bytes[0] = LEAD3 | {4'd0, code[15:12]};
                    job.bytes[1] = CONT | {2'd0, code[11:6]};
                    job.bytes[2] = CONT | {2'd0, code[5:0]};
                    n = 2'd3;
                end
            end
            if (pos_reg < POS_SAT) begin
                pos_next = pos_reg + 2'd1;
            end
        end else begin
            job.bytes[0] = data_byte;
            n = 2'd1;
            job.eot = last_of_frame;
        end

        job.cnt = {1'b0, n};

        // Terminator for ISO-8859-1 and UTF-16 frames, and return to the idle state at frame end
        if (last_of_frame) begin
            if ((mode_next == MODE_ISO) || (mode_next == MODE_U16)) begin
                job.bytes[n] = TERM_BYTE;
                job.cnt      = {1'b0, n} + 3'd1;
                job.eot      = 1'b1;
            end
            mode_next = MODE_RAW;
            pos_next  = 2'd0;
            held_next = '0;
            have_next = 1'b0;
            be_next   = 1'b0;
        end

        push = acc && (job.cnt != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RAW;
            pos_reg  <= 2'd0;
            held_reg <= '0;
            have_reg <= 1'b0;
            be_reg   <= 1'b0;
        end else if (acc) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            held_reg <= held_next;
            have_reg <= have_next;
            be_reg   <= be_next;
        end
    end

endmodule

>>> rtl/i3u8_queue.sv
module i3u8_queue
    import i3u8_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Two-entry store
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

>>> rtl/i3u8_back.sv
module i3u8_back
    import i3u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       tlast_reg;
    logic       tuser_reg;
    logic       out_ok;
    logic       final_byte;

    // Output register free or being drained this cycle
    assign out_ok     = !valid_reg || m_tready;
    assign final_byte = (({1'b0, idx_reg} + 3'd1) == head.cnt);
    assign pop        = out_ok && !empty && final_byte;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

    // Serialise the head job one byte a cycle while the output register is free or being drained
    always_ff @(posedge aclk) begin
        if (out_ok && !empty) begin
            data_reg  <= head.bytes[idx_reg];
            tlast_reg <= head.eot && final_byte;
            tuser_reg <= final_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (out_ok) begin
            valid_reg <= !empty;
            if (!empty) begin
                idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

endmodule

>>> rtl/id3_text_to_utf8.sv
// Path: an accepted request is turned into a job and written into the job queue, and
// the serialiser loads its bytes from the queue head into the output register.
// Throughput: one output byte per cycle from the serialiser while m_tready allows;
// the two-entry job queue lets input requests be taken every cycle while it has room.
// Reset: aresetn is synchronous and active low; it empties the queue and
// returns the frame state to raw copy, little endian.
module id3_text_to_utf8
    import i3u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] first_of_frame
    input  logic       s_tlast,   // last_of_frame
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] last_of_run
    output logic       m_tlast    // end_of_text
);

    logic acc;
    logic push;
    logic pop;
    logic empty;
    logic full;
    job_t push_job;
    job_t head;

    assign s_tready = !full;
    assign acc      = s_tvalid && s_tready;

    i3u8_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .acc            (acc),
        .data_byte      (s_tdata),
        .first_of_frame (s_tuser),
        .last_of_frame  (s_tlast),
        .push           (push),
        .job            (push_job)
    );

    i3u8_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    i3u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import i3u8_pkg::*;

    localparam int IDLE_PCT       = 11;
    localparam int RANDOM_ITEMS   = 145;
    localparam int STALL_AT       = 40;    // requests accepted before the long receiver stall
    localparam int STALL_CYCLES   = 150;
    localparam int CALM_FROM      = 70;    // no idling on either side in this window
    localparam int CALM_TO        = 115;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;
    localparam logic [7:0] ENC_RAW_MIN = ENC_U16 + 8'd1;
    localparam logic [15:0] BOM_UNIT   = {BOM_FE, BOM_FF};

    // One frame byte as it travels on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } frame_byte_t;

    typedef struct {
        frame_byte_t req;
        bit          drain;    // wait for all outstanding output before offering
    } queued_req_t;

    // One UTF-8 byte as it leaves on the output channel
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       run_end;
    } utf8_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    queued_req_t frame_bytes_pending[$];
    utf8_byte_t  utf8_expected[$];
    utf8_byte_t  run_buf[$];
    bit          drain_next = 1'b0;

    // Converter state as the block should hold it
    text_mode_t  cur_mode;
    logic [1:0]  pay_pos;
    logic [7:0]  held;
    logic        have_held;
    logic        big_end;

    logic        req_taken = 1'b0;
    int          accepted_reqs = 0;
    int          out_count = 0;
    int          err_count = 0;
    int          stall_left = 0;
    bit          stall_done = 1'b0;
    bit          watch_on = 1'b0;
    logic        calm;

    assign calm = (accepted_reqs >= CALM_FROM) && (accepted_reqs < CALM_TO);

    id3_text_to_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_frame();
        cur_mode  = MODE_RAW;
        pay_pos   = '0;
        held      = '0;
        have_held = 1'b0;
        big_end   = 1'b0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic eot);
        utf8_byte_t o;
        o.ch      = b;
        o.eot     = eot;
        o.run_end = 1'b0;
        run_buf.push_back(o);
    endfunction

    // Work out the UTF-8 bytes caused by one accepted frame byte
    function automatic void predict_utf8(input frame_byte_t r);
        logic [15:0] unit;
        utf8_byte_t  o;
        run_buf.delete();
        if (r.first) begin
            clear_frame();
            if (r.data == ENC_ISO)
                cur_mode = MODE_ISO;
            else if (r.data == ENC_U16)
                cur_mode = MODE_U16;
            else
                cur_mode = MODE_RAW;
        end else if (cur_mode == MODE_ISO) begin
            if (r.data < CONT) begin
                emit_byte(r.data, 1'b0);
            end else begin
                emit_byte(LEAD2 | {6'b0, r.data[7:6]}, 1'b0);
                emit_byte(CONT | {2'b0, r.data[5:0]}, 1'b0);
            end
        end else if (cur_mode == MODE_U16) begin
            if (!have_held) begin
                held      = r.data;
                have_held = 1'b1;
            end else begin
                have_held = 1'b0;
                // a byte order mark counts only as the first unit of the payload
                if (pay_pos == 2'd1 && ((held == BOM_FE && r.data == BOM_FF) ||
                                        (held == BOM_FF && r.data == BOM_FE))) begin
                    big_end = (held == BOM_FE);
                end else begin
                    unit = big_end ? {held, r.data} : {r.data, held};
                    if (unit <= ONE_MAX) begin
                        emit_byte(unit[7:0], 1'b0);
                    end else if (unit <= TWO_MAX) begin
                        emit_byte(LEAD2 | {3'b0, unit[10:6]}, 1'b0);
                        emit_byte(CONT | {2'b0, unit[5:0]}, 1'b0);
                    end else begin
                        emit_byte(LEAD3 | {4'b0, unit[15:12]}, 1'b0);
                        emit_byte(CONT | {2'b0, unit[11:6]}, 1'b0);
                        emit_byte(CONT | {2'b0, unit[5:0]}, 1'b0);
                    end
                end
            end
            if (pay_pos < POS_SAT)
                pay_pos = pay_pos + 2'd1;
        end else begin
            emit_byte(r.data, r.last);
        end

        if (r.last) begin
            if (cur_mode == MODE_ISO || cur_mode == MODE_U16)
                emit_byte(TERM_BYTE, 1'b1);
            clear_frame();
        end

        foreach (run_buf[i]) begin
            o = run_buf[i];
            o.run_end = (i == run_buf.size() - 1);
            utf8_expected.push_back(o);
        end
    endfunction

    function automatic void add_req(input logic [7:0] d, input logic f, input logic l);
        queued_req_t q;
        q.req.data  = d;
        q.req.first = f;
        q.req.last  = l;
        q.drain     = drain_next;
        drain_next  = 1'b0;
        frame_bytes_pending.push_back(q);
    endfunction

    // Sender: hold a request until taken, idle at random, pause where asked to drain
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_taken) begin
            // request still on offer
        end else if (frame_bytes_pending.size() == 0 ||
                     (!calm && $urandom_range(99) < IDLE_PCT) ||
                     (frame_bytes_pending[0].drain && utf8_expected.size() != 0)) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            {s_tdata, s_tuser, s_tlast} <= frame_bytes_pending[0].req;
        end
    end

    // Receiver: random back-pressure plus one long stall
    always @(negedge aclk) begin
        if (!stall_done && accepted_reqs >= STALL_AT) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: check outputs against the oldest expectation, then predict new requests
    always @(posedge aclk) begin
        utf8_byte_t exp_b;
        req_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            out_count <= out_count + 1;
            if (utf8_expected.size() == 0) begin
                err_count = err_count + 1;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected output byte %02h eot %0b run_end %0b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                exp_b = utf8_expected.pop_front();
                if (m_tdata !== exp_b.ch || m_tlast !== exp_b.eot ||
                    m_tuser !== exp_b.run_end) begin
                    err_count = err_count + 1;
                    if (err_count <= MAX_REPORTS)
                        $display({"mismatch on output %0d: byte exp %02h got %02h, ",
                                  "%s%0b got %0b, %s%0b got %0b"},
                                 out_count, exp_b.ch, m_tdata,
                                 "eot exp ", exp_b.eot, m_tlast,
                                 "run_end exp ", exp_b.run_end, m_tuser);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_utf8({s_tdata, s_tuser, s_tlast});
            void'(frame_bytes_pending.pop_front());
            accepted_reqs <= accepted_reqs + 1;
        end
    end

    // Watchdog on cycles with no transfer on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!watch_on || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= WATCHDOG_LIMIT)
                break;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          n_random;
        int          roll;
        int          n_units;
        int          cls;
        bit          be;
        bit          trunc;
        bit          mid_drain;
        logic [7:0]  enc;
        logic [15:0] unit;
        logic [7:0]  body[$];

        clear_frame();

        // ISO-8859-1: top of ASCII, both halves of the upper range
        add_req(ENC_ISO, 1'b1, 1'b0);
        add_req(8'h7F, 1'b0, 1'b0);
        add_req(8'h80, 1'b0, 1'b0);
        add_req(8'hFF, 1'b0, 1'b1);
        // UTF-16 big endian by mark, mark repeated later as text, odd tail byte dropped
        add_req(ENC_U16, 1'b1, 1'b0);
        add_req(BOM_FE, 1'b0, 1'b0);
        add_req(BOM_FF, 1'b0, 1'b0);
        add_req(8'h00, 1'b0, 1'b0);
        add_req(8'h41, 1'b0, 1'b0);
        add_req(BOM_FF, 1'b0, 1'b0);
        add_req(BOM_FE, 1'b0, 1'b0);
        add_req(8'h12, 1'b0, 1'b1);
        // ISO frame abandoned by a new encoding byte
        add_req(ENC_ISO, 1'b1, 1'b0);
        add_req(8'h41, 1'b0, 1'b0);
        // UTF-16 little endian by mark
        add_req(ENC_U16, 1'b1, 1'b0);
        add_req(BOM_FF, 1'b0, 1'b0);
        add_req(BOM_FE, 1'b0, 1'b0);
        add_req(8'h34, 1'b0, 1'b0);
        add_req(8'h12, 1'b0, 1'b1);
        // encoding byte alone, and a UTF-16 payload of a single byte
        add_req(ENC_ISO, 1'b1, 1'b1);
        add_req(ENC_U16, 1'b1, 1'b0);
        add_req(8'h55, 1'b0, 1'b1);
        // raw frame, then a stray byte outside any frame
        add_req(8'h05, 1'b1, 1'b0);
        add_req(8'hAA, 1'b0, 1'b1);
        add_req(8'h3C, 1'b0, 1'b1);

        // Random frames, with a little noise and some broken frames
        drain_next = 1'b1;
        mid_drain  = 1'b0;
        n_random   = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (!mid_drain && n_random > 100) begin
                drain_next = 1'b1;
                mid_drain  = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 10) begin
                add_req(8'($urandom_range(255)), ($urandom_range(3) == 0),
                        1'($urandom_range(1)));
                n_random = n_random + 1;
            end else begin
                body.delete();
                roll = $urandom_range(99);
                if (roll < 35) begin
                    enc = ENC_ISO;
                    n_units = $urandom_range(6);
                    repeat (n_units)
                        body.push_back(($urandom_range(3) == 0) ?
                                       ($urandom_range(1) ? 8'h7F : 8'h80) :
                                       8'($urandom_range(255)));
                end else if (roll < 80) begin
                    enc = ENC_U16;
                    be = 1'b0;
                    if ($urandom_range(1)) begin
                        be = 1'($urandom_range(1));
                        body.push_back(be ? BOM_FE : BOM_FF);
                        body.push_back(be ? BOM_FF : BOM_FE);
                    end
                    n_units = $urandom_range(4);
                    repeat (n_units) begin
                        cls = $urandom_range(2);
                        if ($urandom_range(15) == 0)
                            unit = BOM_UNIT;
                        else if (cls == 0)
                            unit = 16'($urandom_range(ONE_MAX));
                        else if (cls == 1)
                            unit = 16'($urandom_range(TWO_MAX, ONE_MAX + 1));
                        else
                            unit = 16'($urandom_range(16'hFFFF, TWO_MAX + 1));
                        if (be) begin
                            body.push_back(unit[15:8]);
                            body.push_back(unit[7:0]);
                        end else begin
                            body.push_back(unit[7:0]);
                            body.push_back(unit[15:8]);
                        end
                    end
                    if ($urandom_range(3) == 0)
                        body.push_back(8'($urandom_range(255)));
                end else begin
                    enc = 8'($urandom_range(255, ENC_RAW_MIN));
                    n_units = $urandom_range(6);
                    repeat (n_units)
                        body.push_back(8'($urandom_range(255)));
                end
                // a truncated frame is cut short by the next encoding byte
                trunc = ($urandom_range(99) < 8);
                add_req(enc, 1'b1, (body.size() == 0) && !trunc);
                foreach (body[i])
                    add_req(body[i], 1'b0, (i == body.size() - 1) && !trunc);
                n_random = n_random + 1 + body.size();
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        watch_on = 1'b1;

        while (frame_bytes_pending.size() != 0 || utf8_expected.size() != 0)
            @(posedge aclk);
        watch_on = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display({"Sent %0d frame bytes (ISO-8859-1, UTF-16 both orders, raw, ",
                  "stray and cut frames)"}, accepted_reqs);
        $display("and checked %0d UTF-8 output bytes; %0d mismatches", out_count, err_count);
        if (err_count == 0 && utf8_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/i3u8_pkg.sv
rtl/i3u8_front.sv
rtl/i3u8_queue.sv
rtl/i3u8_back.sv
rtl/id3_text_to_utf8.sv
dv/testbench.sv
